// ===== hdl/rcag_pkg.sv =====
// rcag_pkg: shared constants and types of the rectangular copy address generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rcag_pkg;

  localparam int REG_DIM_W   = 16;
  localparam int REG_PITCH_W = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_ROW_P   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_SLICE_P = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DST_ROW_P   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DST_SLICE_P = 3'd6;

  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  typedef struct packed {
    logic desc;
    logic last;
  } flag_t;

  typedef struct packed {
    logic en_b;
    logic en_c;
    logic en_d;
  } pipe_en_t;

endpackage

// ===== hdl/rcag_ctrl.sv =====
// rcag_ctrl: job state, row and slice walk, first pipeline register
// depends on rcag_pkg
`timescale 1ns / 1ps

module rcag_ctrl #(
  parameter int DIM_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic                             in_op,
  input  logic [DIM_BITS-1:0]              in_src_x,
  input  logic [DIM_BITS-1:0]              in_src_y,
  input  logic [DIM_BITS-1:0]              in_src_z,
  input  logic [DIM_BITS-1:0]              in_dst_x,
  input  logic [DIM_BITS-1:0]              in_dst_y,
  input  logic [DIM_BITS-1:0]              in_dst_z,
  input  logic [rcag_pkg::REG_DIM_W-1:0]   cfg_height,
  input  logic [rcag_pkg::REG_DIM_W-1:0]   cfg_depth,
  output logic [DIM_BITS-1:0]              src_x_a,
  output logic [DIM_BITS:0]                src_ry_a,
  output logic [DIM_BITS:0]                src_rz_a,
  output logic [DIM_BITS-1:0]              dst_x_a,
  output logic [DIM_BITS:0]                dst_ry_a,
  output logic [DIM_BITS:0]                dst_rz_a,
  output rcag_pkg::flag_t                  flag_a
);
  import rcag_pkg::*;

  localparam int CMP_W = (DIM_BITS > REG_DIM_W) ? DIM_BITS : REG_DIM_W;

  logic                active_r, active_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt, slice_r, slice_nxt;
  logic [DIM_BITS-1:0] sx_r, sy_r, sz_r, dx_r, dy_r, dz_r;
  logic [DIM_BITS-1:0] row_inc, slice_inc;
  logic                use_z;

  logic [DIM_BITS-1:0] src_x_nxt, dst_x_nxt;
  logic [DIM_BITS:0]   src_ry_nxt, src_rz_nxt, dst_ry_nxt, dst_rz_nxt;
  flag_t               flag_nxt;

  assign row_inc   = row_r + 1'b1;
  assign slice_inc = slice_r + 1'b1;
  assign use_z     = (cfg_depth != '0);

  always_comb begin
    active_nxt = active_r;
    row_nxt    = row_r;
    slice_nxt  = slice_r;
    src_x_nxt  = '0;
    dst_x_nxt  = '0;
    src_ry_nxt = '0;
    src_rz_nxt = '0;
    dst_ry_nxt = '0;
    dst_rz_nxt = '0;
    flag_nxt   = '0;
    if (in_op == OP_START) begin
      active_nxt = 1'b1;
      row_nxt    = '0;
      slice_nxt  = '0;
    end else if (active_r) begin
      if (use_z && cfg_height == '0) begin
        // empty mode
        active_nxt = 1'b0;
      end else if (cfg_height == '0) begin
        // single run
        flag_nxt.desc = 1'b1;
        flag_nxt.last = 1'b1;
        src_x_nxt     = sx_r;
        dst_x_nxt     = dx_r;
        active_nxt    = 1'b0;
      end else begin
        flag_nxt.desc = 1'b1;
        src_x_nxt     = sx_r;
        dst_x_nxt     = dx_r;
        src_ry_nxt    = {1'b0, sy_r} + {1'b0, row_r};
        dst_ry_nxt    = {1'b0, dy_r} + {1'b0, row_r};
        if (use_z) begin
          src_rz_nxt = {1'b0, sz_r} + {1'b0, slice_r};
          dst_rz_nxt = {1'b0, dz_r} + {1'b0, slice_r};
        end
        row_nxt = row_inc;
        if (row_inc == '0 || CMP_W'(row_inc) >= CMP_W'(cfg_height)) begin
          row_nxt = '0;
          if (!use_z) begin
            flag_nxt.last = 1'b1;
          end else begin
            slice_nxt = slice_inc;
            if (slice_inc == '0 || CMP_W'(slice_inc) >= CMP_W'(cfg_depth)) begin
              flag_nxt.last = 1'b1;
            end
          end
        end
        if (flag_nxt.last) begin
          active_nxt = 1'b0;
          row_nxt    = '0;
          slice_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      row_r    <= '0;
      slice_r  <= '0;
      sx_r     <= '0;
      sy_r     <= '0;
      sz_r     <= '0;
      dx_r     <= '0;
      dy_r     <= '0;
      dz_r     <= '0;
    end else if (accept) begin
      active_r <= active_nxt;
      row_r    <= row_nxt;
      slice_r  <= slice_nxt;
      if (in_op == OP_START) begin
        sx_r <= in_src_x;
        sy_r <= in_src_y;
        sz_r <= in_src_z;
        dx_r <= in_dst_x;
        dy_r <= in_dst_y;
        dz_r <= in_dst_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      src_x_a  <= src_x_nxt;
      src_ry_a <= src_ry_nxt;
      src_rz_a <= src_rz_nxt;
      dst_x_a  <= dst_x_nxt;
      dst_ry_a <= dst_ry_nxt;
      dst_rz_a <= dst_rz_nxt;
      flag_a   <= flag_nxt;
    end
  end

endmodule

// ===== hdl/rcag_offset.sv =====
// rcag_offset: x + row * row step + slice * slice step over three registered stages
// depends on rcag_pkg; one instance per side
`timescale 1ns / 1ps

module rcag_offset #(
  parameter int DIM_BITS  = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic                             clk,
  input  rcag_pkg::pipe_en_t               en,
  input  logic [DIM_BITS-1:0]              x_a,
  input  logic [DIM_BITS:0]                ry_a,
  input  logic [DIM_BITS:0]                rz_a,
  input  logic [rcag_pkg::REG_DIM_W-1:0]   cfg_width,
  input  logic [rcag_pkg::REG_DIM_W-1:0]   cfg_height,
  input  logic [rcag_pkg::REG_PITCH_W-1:0] cfg_row_step,
  input  logic [rcag_pkg::REG_PITCH_W-1:0] cfg_slice_step,
  output logic [ADDR_BITS-1:0]             offset_d,
  output logic                             ovf_d
);
  import rcag_pkg::*;

  localparam int CW      = DIM_BITS + 1;
  localparam int PR_W    = CW + REG_PITCH_W;
  localparam int SP_W    = REG_DIM_W + REG_PITCH_W;
  localparam int PZ_W    = CW + SP_W;
  localparam int PS_W    = PR_W + 1;
  localparam int SUM_RAW = PZ_W + 1;
  localparam int SUM_W   = (SUM_RAW > ADDR_BITS) ? SUM_RAW : ADDR_BITS + 1;

  logic [REG_PITCH_W-1:0] rp_eff;
  logic [SP_W-1:0]        sp_dflt, sp_eff;
  logic [PR_W-1:0]        pr;
  logic [PZ_W-1:0]        pz;
  logic [PS_W-1:0]        ps;
  logic [SUM_W-1:0]       sum;

  logic [DIM_BITS-1:0]    x_b_r;
  logic [PR_W-1:0]        pr_b_r;
  logic [CW-1:0]          rz_b_r;
  logic [SP_W-1:0]        sp_b_r;
  logic [PS_W-1:0]        ps_c_r;
  logic [PZ_W-1:0]        pz_c_r;

  assign rp_eff  = (cfg_row_step != '0) ? cfg_row_step : REG_PITCH_W'(cfg_width);
  assign sp_dflt = SP_W'(cfg_height) * SP_W'(rp_eff);
  assign sp_eff  = (cfg_slice_step != '0) ? SP_W'(cfg_slice_step) : sp_dflt;
  assign pr      = PR_W'(ry_a) * PR_W'(rp_eff);

  always_ff @(posedge clk) begin
    if (en.en_b) begin
      x_b_r  <= x_a;
      pr_b_r <= pr;
      rz_b_r <= rz_a;
      sp_b_r <= sp_eff;
    end
  end

  assign ps = PS_W'(x_b_r) + PS_W'(pr_b_r);
  assign pz = PZ_W'(rz_b_r) * PZ_W'(sp_b_r);

  always_ff @(posedge clk) begin
    if (en.en_c) begin
      ps_c_r <= ps;
      pz_c_r <= pz;
    end
  end

  assign sum = SUM_W'(ps_c_r) + SUM_W'(pz_c_r);

  always_ff @(posedge clk) begin
    if (en.en_d) begin
      offset_d <= sum[ADDR_BITS-1:0];
      ovf_d    <= |sum[SUM_W-1:ADDR_BITS];
    end
  end

endmodule

// ===== hdl/rect_copy_address_generator_top.sv =====
// rect_copy_address_generator_top: row descriptor generator for 3d rectangular copies
// depends on rcag_pkg, rcag_ctrl, rcag_offset
//
//   channel   direction  handshake          payload
//   in_       input      in_valid/in_ready  op, src_x/y/z, dst_x/y/z
//   out_      output     out_valid/out_ready valid_res, dst/src_offset, length, last_row, overflow
//   cfg_      input      cfg_we             cfg_index, cfg_wdata
//
// one word accepted per cycle while in_ready is high; the row/slice walk advances on each accepted word
// a result for an accepted word passes through four registers:
// walk register, row multiply, slice multiply, final add and overflow check
// reset is synchronous, clears the registers, the walk state and the pipeline valid bits
// a stalled output holds; earlier stages keep filling until every stage holds a word
`timescale 1ns / 1ps

module rect_copy_address_generator_top #(
  parameter int DIM_BITS  = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [DIM_BITS-1:0]             in_src_x,
  input  logic [DIM_BITS-1:0]             in_src_y,
  input  logic [DIM_BITS-1:0]             in_src_z,
  input  logic [DIM_BITS-1:0]             in_dst_x,
  input  logic [DIM_BITS-1:0]             in_dst_y,
  input  logic [DIM_BITS-1:0]             in_dst_z,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_valid_res,
  output logic [ADDR_BITS-1:0]            out_dst_offset,
  output logic [ADDR_BITS-1:0]            out_src_offset,
  output logic [rcag_pkg::REG_DIM_W-1:0]  out_length,
  output logic                            out_last_row,
  output logic                            out_overflow,
  input  logic                            cfg_we,
  input  logic [rcag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcag_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rcag_pkg::*;

  logic [REG_DIM_W-1:0]   width_r, height_r, depth_r;
  logic [REG_PITCH_W-1:0] src_rp_r, src_sp_r, dst_rp_r, dst_sp_r;

  logic     v_a_r, v_b_r, v_c_r, v_d_r;
  logic     free_a, free_b, free_c, free_d;
  logic     accept;
  pipe_en_t en;
  flag_t    flag_a, flag_b_r, flag_c_r, flag_d_r;

  logic [DIM_BITS-1:0]  src_x_a, dst_x_a;
  logic [DIM_BITS:0]    src_ry_a, src_rz_a, dst_ry_a, dst_rz_a;
  logic [ADDR_BITS-1:0] src_off, dst_off;
  logic                 src_ovf, dst_ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      depth_r  <= '0;
      src_rp_r <= '0;
      src_sp_r <= '0;
      dst_rp_r <= '0;
      dst_sp_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:       width_r  <= cfg_wdata[REG_DIM_W-1:0];
        REG_HEIGHT:      height_r <= cfg_wdata[REG_DIM_W-1:0];
        REG_DEPTH:       depth_r  <= cfg_wdata[REG_DIM_W-1:0];
        REG_SRC_ROW_P:   src_rp_r <= cfg_wdata[REG_PITCH_W-1:0];
        REG_SRC_SLICE_P: src_sp_r <= cfg_wdata[REG_PITCH_W-1:0];
        REG_DST_ROW_P:   dst_rp_r <= cfg_wdata[REG_PITCH_W-1:0];
        REG_DST_SLICE_P: dst_sp_r <= cfg_wdata[REG_PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // bubble-collapsing stage control
  assign free_d  = !v_d_r || out_ready;
  assign free_c  = !v_c_r || free_d;
  assign free_b  = !v_b_r || free_c;
  assign free_a  = !v_a_r || free_b;
  assign in_ready = free_a;
  assign accept   = in_valid && free_a;

  assign en.en_b = free_b && v_a_r;
  assign en.en_c = free_c && v_b_r;
  assign en.en_d = free_d && v_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
    end else begin
      if (free_a) v_a_r <= in_valid;
      if (free_b) v_b_r <= v_a_r;
      if (free_c) v_c_r <= v_b_r;
      if (free_d) v_d_r <= v_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.en_b) flag_b_r <= flag_a;
    if (en.en_c) flag_c_r <= flag_b_r;
    if (en.en_d) flag_d_r <= flag_c_r;
  end

  rcag_ctrl #(
    .DIM_BITS (DIM_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_op      (in_op),
    .in_src_x   (in_src_x),
    .in_src_y   (in_src_y),
    .in_src_z   (in_src_z),
    .in_dst_x   (in_dst_x),
    .in_dst_y   (in_dst_y),
    .in_dst_z   (in_dst_z),
    .cfg_height (height_r),
    .cfg_depth  (depth_r),
    .src_x_a    (src_x_a),
    .src_ry_a   (src_ry_a),
    .src_rz_a   (src_rz_a),
    .dst_x_a    (dst_x_a),
    .dst_ry_a   (dst_ry_a),
    .dst_rz_a   (dst_rz_a),
    .flag_a     (flag_a)
  );

  rcag_offset #(
    .DIM_BITS  (DIM_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_src_off (
    .clk            (clk),
    .en             (en),
    .x_a            (src_x_a),
    .ry_a           (src_ry_a),
    .rz_a           (src_rz_a),
    .cfg_width      (width_r),
    .cfg_height     (height_r),
    .cfg_row_step   (src_rp_r),
    .cfg_slice_step (src_sp_r),
    .offset_d       (src_off),
    .ovf_d          (src_ovf)
  );

  rcag_offset #(
    .DIM_BITS  (DIM_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dst_off (
    .clk            (clk),
    .en             (en),
    .x_a            (dst_x_a),
    .ry_a           (dst_ry_a),
    .rz_a           (dst_rz_a),
    .cfg_width      (width_r),
    .cfg_height     (height_r),
    .cfg_row_step   (dst_rp_r),
    .cfg_slice_step (dst_sp_r),
    .offset_d       (dst_off),
    .ovf_d          (dst_ovf)
  );

  // words without a descriptor carry zeros
  assign out_valid      = v_d_r;
  assign out_valid_res  = flag_d_r.desc;
  assign out_dst_offset = flag_d_r.desc ? dst_off : '0;
  assign out_src_offset = flag_d_r.desc ? src_off : '0;
  assign out_length     = flag_d_r.desc ? width_r : '0;
  assign out_last_row   = flag_d_r.desc && flag_d_r.last;
  assign out_overflow   = flag_d_r.desc && (src_ovf || dst_ovf);

endmodule

// ===== hdl/rcag_checker.sv =====
// rcag_checker: port-level assertions for rect_copy_address_generator_top
// depends on rcag_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module rcag_checker #(
  parameter int ADDR_BITS = 32
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_valid_res,
  input logic [ADDR_BITS-1:0]           out_dst_offset,
  input logic [ADDR_BITS-1:0]           out_src_offset,
  input logic [rcag_pkg::REG_DIM_W-1:0] out_length,
  input logic                           out_last_row,
  input logic                           out_overflow
);
  import rcag_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_valid_res) &&
      $stable(out_dst_offset) && $stable(out_src_offset) && $stable(out_length) &&
      $stable(out_last_row) && $stable(out_overflow))
    else $error("result word changed while stalled");

  // a word without a descriptor carries zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_dst_offset == '0 && out_src_offset == '0 &&
      out_length == '0 && !out_last_row && !out_overflow)
    else $error("empty result word carries nonzero fields");

  // last row and overflow only on descriptors
  a_flags_desc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_last_row || out_overflow) |-> out_valid_res)
    else $error("flag set on word without descriptor");

  // empty output stage means the whole pipeline can take a word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with empty output stage");

  // nothing comes out right after reset
  a_reset_clear: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result word valid after reset");

endmodule

bind rect_copy_address_generator_top rcag_checker #(
  .ADDR_BITS (ADDR_BITS)
) u_rcag_checker (.*);

// ===== dv/rcag_row_checker.sv =====
// rcag_row_checker: watches the word, result and register ports of the address generator,
// predicts every row descriptor and compares it field by field with what the block returns
// depends on rcag_pkg
`timescale 1ns / 1ps

module rcag_row_checker #(
  parameter int DIM_BITS  = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_op,
  input  logic [DIM_BITS-1:0]             in_src_x,
  input  logic [DIM_BITS-1:0]             in_src_y,
  input  logic [DIM_BITS-1:0]             in_src_z,
  input  logic [DIM_BITS-1:0]             in_dst_x,
  input  logic [DIM_BITS-1:0]             in_dst_y,
  input  logic [DIM_BITS-1:0]             in_dst_z,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_valid_res,
  input  logic [ADDR_BITS-1:0]            out_dst_offset,
  input  logic [ADDR_BITS-1:0]            out_src_offset,
  input  logic [rcag_pkg::REG_DIM_W-1:0]  out_length,
  input  logic                            out_last_row,
  input  logic                            out_overflow,
  input  logic                            cfg_we,
  input  logic [rcag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcag_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              mismatch_count,
  output int                              rows_outstanding
);
  import rcag_pkg::*;

  typedef struct packed {
    logic                 has_row;
    logic [ADDR_BITS-1:0] dst_offset;
    logic [ADDR_BITS-1:0] src_offset;
    logic [REG_DIM_W-1:0] length;
    logic                 last_row;
    logic                 overflow;
  } row_desc_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] x;
    logic [DIM_BITS-1:0] y;
    logic [DIM_BITS-1:0] z;
  } origin_t;

  logic [REG_DIM_W-1:0]   region_w, region_h, region_d;
  logic [REG_PITCH_W-1:0] src_row_p, src_slice_p, dst_row_p, dst_slice_p;
  logic                   job_armed;
  logic [DIM_BITS-1:0]    cur_row, cur_slice;
  origin_t                src_org, dst_org;
  row_desc_t              expected_rows[$];

  // exact offset, wide enough that nothing is lost before the wrap check
  function automatic logic [127:0] exact_offset(origin_t org, logic [63:0] row_p,
                                                logic [63:0] slice_p, logic with_slice);
    logic [127:0] sum;
    sum = 128'(org.x) + (128'(org.y) + 128'(cur_row)) * 128'(row_p);
    if (with_slice) begin
      sum = sum + (128'(org.z) + 128'(cur_slice)) * 128'(slice_p);
    end
    return sum;
  endfunction

  function automatic row_desc_t predict_row(logic op, origin_t s_org, origin_t d_org);
    row_desc_t           r;
    logic [63:0]         srp, drp, ssp, dsp;
    logic [127:0]        s_exact, d_exact;
    logic [DIM_BITS-1:0] nxt_row, nxt_slice;
    logic                with_slice;
    r = '0;
    if (op == OP_START) begin
      src_org   = s_org;
      dst_org   = d_org;
      cur_row   = '0;
      cur_slice = '0;
      job_armed = 1'b1;
    end else if (!job_armed) begin
      r = '0;
    end else if (region_d != 0 && region_h == 0) begin
      job_armed = 1'b0;
    end else if (region_h == 0) begin
      // single run
      r.has_row    = 1'b1;
      r.dst_offset = ADDR_BITS'(dst_org.x);
      r.src_offset = ADDR_BITS'(src_org.x);
      r.length     = region_w;
      r.last_row   = 1'b1;
      job_armed    = 1'b0;
    end else begin
      srp = (src_row_p != 0) ? 64'(src_row_p) : 64'(region_w);
      drp = (dst_row_p != 0) ? 64'(dst_row_p) : 64'(region_w);
      ssp = (src_slice_p != 0) ? 64'(src_slice_p) : 64'(region_h) * srp;
      dsp = (dst_slice_p != 0) ? 64'(dst_slice_p) : 64'(region_h) * drp;
      with_slice   = (region_d != 0);
      d_exact      = exact_offset(dst_org, drp, dsp, with_slice);
      s_exact      = exact_offset(src_org, srp, ssp, with_slice);
      r.has_row    = 1'b1;
      r.dst_offset = d_exact[ADDR_BITS-1:0];
      r.src_offset = s_exact[ADDR_BITS-1:0];
      r.length     = region_w;
      r.overflow   = (|d_exact[127:ADDR_BITS]) || (|s_exact[127:ADDR_BITS]);
      nxt_row = cur_row + 1'b1;
      if (nxt_row == 0 || nxt_row >= region_h) begin
        cur_row = '0;
        if (!with_slice) begin
          r.last_row = 1'b1;
        end else begin
          nxt_slice = cur_slice + 1'b1;
          cur_slice = nxt_slice;
          if (nxt_slice == 0 || nxt_slice >= region_d) begin
            r.last_row = 1'b1;
          end
        end
      end else begin
        cur_row = nxt_row;
      end
      if (r.last_row) begin
        job_armed = 1'b0;
        cur_row   = '0;
        cur_slice = '0;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 200) begin
      $display("%0t ns: row descriptor mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    row_desc_t want;
    if (!rst_n) begin
      region_w    = '0;
      region_h    = '0;
      region_d    = '0;
      src_row_p   = '0;
      src_slice_p = '0;
      dst_row_p   = '0;
      dst_slice_p = '0;
      job_armed   = 1'b0;
      cur_row     = '0;
      cur_slice   = '0;
      src_org     = '0;
      dst_org     = '0;
      expected_rows.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:       region_w    = cfg_wdata[REG_DIM_W-1:0];
          REG_HEIGHT:      region_h    = cfg_wdata[REG_DIM_W-1:0];
          REG_DEPTH:       region_d    = cfg_wdata[REG_DIM_W-1:0];
          REG_SRC_ROW_P:   src_row_p   = cfg_wdata[REG_PITCH_W-1:0];
          REG_SRC_SLICE_P: src_slice_p = cfg_wdata[REG_PITCH_W-1:0];
          REG_DST_ROW_P:   dst_row_p   = cfg_wdata[REG_PITCH_W-1:0];
          REG_DST_SLICE_P: dst_slice_p = cfg_wdata[REG_PITCH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_rows.insert(expected_rows.size(),
                             predict_row(in_op, {in_src_x, in_src_y, in_src_z},
                                         {in_dst_x, in_dst_y, in_dst_z}));
      end
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = expected_rows.pop_front();
          if (out_valid_res !== want.has_row)
            report_mismatch($sformatf("valid_res got %b want %b", out_valid_res, want.has_row));
          if (out_dst_offset !== want.dst_offset)
            report_mismatch($sformatf("dst_offset got %h want %h", out_dst_offset,
                                      want.dst_offset));
          if (out_src_offset !== want.src_offset)
            report_mismatch($sformatf("src_offset got %h want %h", out_src_offset,
                                      want.src_offset));
          if (out_length !== want.length)
            report_mismatch($sformatf("length got %h want %h", out_length, want.length));
          if (out_last_row !== want.last_row)
            report_mismatch($sformatf("last_row got %b want %b", out_last_row, want.last_row));
          if (out_overflow !== want.overflow)
            report_mismatch($sformatf("overflow got %b want %b", out_overflow, want.overflow));
        end
      end
    end
    rows_outstanding = expected_rows.size();
  end

endmodule

// ===== dv/rect_copy_address_generator_top_tb.sv =====
// rect_copy_address_generator_top_tb: drives origins, row requests and register writes into
// the address generator under bursty input and stalling output; verdict from rcag_row_checker
// depends on rcag_pkg, rect_copy_address_generator_top, rcag_row_checker
`timescale 1ns / 1ps

module rect_copy_address_generator_top_tb;
  import rcag_pkg::*;

  localparam int DIM_BITS    = 16;
  localparam int ADDR_BITS   = 32;
  localparam int RANDOM_WORDS = 1150;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef enum {RX_OPEN, RX_COIN, RX_SHUT, RX_TOGGLE} rx_style_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_op;
  logic [DIM_BITS-1:0]   in_src_x, in_src_y, in_src_z;
  logic [DIM_BITS-1:0]   in_dst_x, in_dst_y, in_dst_z;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_valid_res;
  logic [ADDR_BITS-1:0]  out_dst_offset;
  logic [ADDR_BITS-1:0]  out_src_offset;
  logic [REG_DIM_W-1:0]  out_length;
  logic                  out_last_row;
  logic                  out_overflow;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatch_count;
  int                    rows_outstanding;

  int                    cycle_count;
  int                    words_sent;
  int                    burst_left;
  logic                  no_gaps;
  logic                  hold_off_req;
  logic [REG_DIM_W-1:0]  plan_height, plan_depth;

  rect_copy_address_generator_top #(
    .DIM_BITS (DIM_BITS),
    .ADDR_BITS(ADDR_BITS)
  ) uut (.*);

  rcag_row_checker #(
    .DIM_BITS (DIM_BITS),
    .ADDR_BITS(ADDR_BITS)
  ) row_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[rect_copy_address_generator_top] ERROR");
      $finish;
    end
  end

  function automatic logic [DIM_BITS-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return '1;
      1:       return DIM_BITS'($urandom);
      default: return DIM_BITS'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [REG_DIM_W-1:0] rand_dim();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return REG_DIM_W'($urandom);
      default: return REG_DIM_W'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic logic [REG_PITCH_W-1:0] rand_pitch();
    case ($urandom_range(0, 5))
      0, 1:    return '0;
      2:       return '1;
      3:       return REG_PITCH_W'($urandom);
      default: return REG_PITCH_W'($urandom_range(1, 4096));
    endcase
  endfunction

  // sender bursts: a random gap, which may be empty, opens before each new burst
  task automatic send_word(input logic op, input logic [DIM_BITS-1:0] sx, sy, sz,
                           input logic [DIM_BITS-1:0] dx, dy, dz);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_op    = op;
    in_src_x = sx;
    in_src_y = sy;
    in_src_z = sz;
    in_dst_x = dx;
    in_dst_y = dy;
    in_dst_z = dz;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_next();
    send_word(OP_NEXT, rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic drain_words();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (rows_outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_HEIGHT) plan_height = value[REG_DIM_W-1:0];
    if (idx == REG_DEPTH) plan_depth = value[REG_DIM_W-1:0];
  endtask

  task automatic program_phase(input int phase_no);
    logic [CFG_DATA_W-1:0] vals [7];
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom & 32'hFFFF_0000;
    if (phase_no == 0) begin
      foreach (vals[i]) vals[i] = '1;
    end else if (phase_no == 1) begin
      foreach (vals[i]) vals[i] = '0;
    end else begin
      vals[REG_WIDTH]       = junk | 32'($urandom_range(0, 65535));
      vals[REG_HEIGHT]      = junk | 32'(rand_dim());
      vals[REG_DEPTH]       = junk | ($urandom_range(0, 2) == 0 ? 32'd0 : 32'(rand_dim()));
      vals[REG_SRC_ROW_P]   = rand_pitch();
      vals[REG_SRC_SLICE_P] = rand_pitch();
      vals[REG_DST_ROW_P]   = rand_pitch();
      vals[REG_DST_SLICE_P] = rand_pitch();
    end
    for (int i = 0; i < 7; i++) begin
      if (phase_no < 2 || $urandom_range(0, 3) != 0) write_reg(CFG_IDX_W'(i), vals[i]);
    end
  endtask

  // one start and the rows of its job, sometimes cut short or with one request too many
  task automatic run_job();
    longint rows;
    int     n;
    if (plan_height == 0) rows = 1;
    else if (plan_depth == 0) rows = plan_height;
    else rows = longint'(plan_height) * longint'(plan_depth);
    n = (rows > 24) ? $urandom_range(1, 24) : int'(rows);
    if ($urandom_range(0, 5) == 0) n = $urandom_range(0, n);
    else if ($urandom_range(0, 5) == 0) n++;
    send_word(OP_START, rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_coord());
    repeat (n) send_next();
  endtask

  // receiver stall pattern
  initial begin
    rx_style_t style;
    int        seg;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        @(negedge clk);
        out_ready = 1'b0;
        repeat (64) @(negedge clk);
      end
      style = rx_style_t'($urandom_range(0, 3));
      seg = (style == RX_SHUT) ? $urandom_range(1, 4) : $urandom_range(1, 30);
      repeat (seg) begin
        @(negedge clk);
        case (style)
          RX_OPEN:   out_ready = 1'b1;
          RX_COIN:   out_ready = 1'($urandom_range(0, 1));
          RX_SHUT:   out_ready = 1'b0;
          RX_TOGGLE: out_ready = ~out_ready;
          default:   out_ready = 1'b1;
        endcase
      end
    end
  end

  initial begin
    int phase_no;
    int phase_start;
    int target;
    int random_words;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_op        = OP_START;
    in_src_x     = '0;
    in_src_y     = '0;
    in_src_z     = '0;
    in_dst_x     = '0;
    in_dst_y     = '0;
    in_dst_z     = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_WIDTH;
    cfg_wdata    = '0;
    no_gaps      = 1'b0;
    hold_off_req = 1'b0;
    burst_left   = 0;
    plan_height  = '0;
    plan_depth   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset registers: single run of zero length, requests with no job
    send_next();
    send_word(OP_START, '1, '1, '1, '1, '1, '1);
    send_next();
    send_next();
    drain_words();

    // full three-dimensional walk with default pitches, wrap at the top corner
    write_reg(REG_WIDTH, 32'h0000_FFFF);
    write_reg(REG_HEIGHT, 32'd2);
    write_reg(REG_DEPTH, 32'd2);
    write_reg(REG_SRC_ROW_P, 32'd0);
    write_reg(REG_SRC_SLICE_P, 32'd0);
    write_reg(REG_DST_ROW_P, 32'd0);
    write_reg(REG_DST_SLICE_P, 32'd0);
    send_word(OP_START, '1, '1, '1, '1, '1, '1);
    repeat (4) send_next();
    send_word(OP_START, '0, '0, '0, '0, '0, '0);
    send_next();
    // restart in the middle of a job
    send_word(OP_START, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6);
    repeat (4) send_next();
    drain_words();

    // slices with no rows: the job ends without a descriptor
    write_reg(REG_DEPTH, 32'd3);
    write_reg(REG_HEIGHT, 32'd0);
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    send_word(OP_START, rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_coord());
    send_next();
    send_next();
    drain_words();

    // rows only, largest pitches, then the height shrinks under a running job
    write_reg(REG_HEIGHT, 32'd3);
    write_reg(REG_DEPTH, 32'd0);
    write_reg(REG_SRC_ROW_P, 32'hFFFF_FFFF);
    write_reg(REG_SRC_SLICE_P, 32'hFFFF_FFFF);
    write_reg(REG_DST_ROW_P, 32'hFFFF_FFFF);
    write_reg(REG_DST_SLICE_P, 32'hFFFF_FFFF);
    send_word(OP_START, '1, '1, '1, '1, '1, '1);
    send_next();
    send_next();
    drain_words();
    write_reg(REG_HEIGHT, 32'd1);
    send_next();
    send_next();

    random_words = 0;
    phase_no = 0;
    while (random_words < RANDOM_WORDS) begin
      drain_words();
      program_phase(phase_no);
      no_gaps = (phase_no % 4 == 3);
      if (phase_no == 2 || phase_no == 6) hold_off_req = 1'b1;
      target = $urandom_range(60, 120);
      phase_start = words_sent;
      while (words_sent - phase_start < target) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            send_word(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord());
          end
        end else begin
          run_job();
        end
      end
      random_words += words_sent - phase_start;
      phase_no++;
    end

    drain_words();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[rect_copy_address_generator_top] OK");
    end else begin
      $display("[rect_copy_address_generator_top] ERROR");
    end
    $finish;
  end

endmodule
